/* rtl/chs_pkg.sv */
// Package for the compass heading sector block: widths, arctangent table,
// axis and sector codes, the CORDIC pipeline payload and the sector decoder.
// No dependencies.
`default_nettype none

package chs_pkg;

  localparam int SAMPLE_BITS   = 13;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NSTG          = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  localparam int XY_W    = SAMPLE_BITS + 4;
  localparam int ACC_W   = 25;
  localparam int HEAD_W  = 15;
  localparam int WRAP_W  = 18;
  localparam int RAW_SHIFT = 10;

  localparam int DEG         = 64;
  localparam int FULL_CIRCLE = 360 * DEG;

  localparam logic signed [ACC_W-1:0] ACC_90   = ACC_W'(90 * 65536);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(512);

  localparam logic signed [WRAP_W-1:0] TWO_CIRCLE_S = WRAP_W'(2 * FULL_CIRCLE);
  localparam logic [WRAP_W-2:0] ONE_CIRCLE_U = (WRAP_W-1)'(FULL_CIRCLE);
  localparam logic [WRAP_W-2:0] TWO_CIRCLE_U = (WRAP_W-1)'(2 * FULL_CIRCLE);

  localparam logic [HEAD_W-1:0] B_N_HI  = HEAD_W'(345 * DEG);
  localparam logic [HEAD_W-1:0] B_N_LO  = HEAD_W'(15 * DEG);
  localparam logic [HEAD_W-1:0] B_NE    = HEAD_W'(75 * DEG);
  localparam logic [HEAD_W-1:0] B_E     = HEAD_W'(105 * DEG);
  localparam logic [HEAD_W-1:0] B_SE    = HEAD_W'(165 * DEG);
  localparam logic [HEAD_W-1:0] B_S     = HEAD_W'(195 * DEG);
  localparam logic [HEAD_W-1:0] B_SW    = HEAD_W'(255 * DEG);
  localparam logic [HEAD_W-1:0] B_W     = HEAD_W'(285 * DEG);

  localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    ACC_W'(2949120), ACC_W'(1740967), ACC_W'(919879), ACC_W'(466945),
    ACC_W'(234379),  ACC_W'(117304),  ACC_W'(58666),  ACC_W'(29335),
    ACC_W'(14668),   ACC_W'(7334),    ACC_W'(3667),   ACC_W'(1833),
    ACC_W'(917),     ACC_W'(458),     ACC_W'(229),    ACC_W'(115),
    ACC_W'(57),      ACC_W'(29),      ACC_W'(14),     ACC_W'(7),
    ACC_W'(4),       ACC_W'(2),       ACC_W'(1),      ACC_W'(0)
  };

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef enum logic [2:0] {
    SEC_N  = 3'd0,
    SEC_NE = 3'd1,
    SEC_E  = 3'd2,
    SEC_SE = 3'd3,
    SEC_S  = 3'd4,
    SEC_SW = 3'd5,
    SEC_W  = 3'd6,
    SEC_NW = 3'd7
  } sector_e;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
    logic                    bad;
  } cordic_t;

  function automatic sector_e sector_of(input logic [HEAD_W-1:0] h);
    sector_e s;
    priority if (h >= B_N_HI || h < B_N_LO) s = SEC_N;
    else if (h < B_NE) s = SEC_NE;
    else if (h < B_E)  s = SEC_E;
    else if (h < B_SE) s = SEC_SE;
    else if (h <= B_S)  s = SEC_S;
    else if (h <= B_SW) s = SEC_SW;
    else if (h <= B_W)  s = SEC_W;
    else s = SEC_NW;
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/compass_heading_sector_core.sv */
// Top level of the compass heading sector block: axis select and pre-rotation,
// the CORDIC pipeline, declination subtract, wrap and sector decode.
// Depends on chs_pkg and chs_cordic.
`default_nettype none

// The block takes one magnetometer sample per clock cycle while in_stall_o is
// low and returns its heading and compass sector through one front stage, one
// stage per CORDIC rotation (sixteen), and three back stages. Every stage
// carries its own valid bit, so a stalled output only holds the pipeline once
// all stages in front of it are occupied. The declination register is read by
// the first back stage and should be written while no transaction is in flight.
module compass_heading_sector_core import chs_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [HEAD_W-1:0]             cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] field_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] field_y_i,
  input  wire logic signed [SAMPLE_BITS-1:0] field_z_i,
  input  wire logic [1:0]                    rotation_axis_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [HEAD_W-1:0]                  heading_o,
  output logic [2:0]                         compass_sector_o,
  output logic                               bad_axis_o
);

  logic [HEAD_W-1:0] heading_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_offset_q <= HEAD_W'(30 * DEG);
    end else if (cfg_we_i) begin
      heading_offset_q <= cfg_wdata_i;
    end
  end

  logic adv_f, adv_p1, adv_p2, adv_o;
  logic cordic_in_stall, cordic_valid;
  cordic_t cordic_out;

  logic    f_valid_q;
  cordic_t f_q, f_d;
  logic signed [XY_W-1:0] num, den;
  logic axis_bad;

  always_comb begin
    axis_bad = 1'b0;
    unique case (axis_e'(rotation_axis_i))
      AXIS_X: begin
        num = XY_W'(field_y_i);
        den = XY_W'(field_z_i);
      end
      AXIS_Y: begin
        num = XY_W'(field_x_i);
        den = XY_W'(field_z_i);
      end
      AXIS_Z: begin
        num = XY_W'(field_x_i);
        den = XY_W'(field_y_i);
      end
      default: begin
        num      = '0;
        den      = '0;
        axis_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    f_d.bad  = axis_bad;
    f_d.zero = (num == '0) && (den == '0);
    if (den[XY_W-1]) begin
      if (!num[XY_W-1]) begin
        f_d.x   = num;
        f_d.y   = -den;
        f_d.acc = ACC_90;
      end else begin
        f_d.x   = -num;
        f_d.y   = den;
        f_d.acc = -ACC_90;
      end
    end else begin
      f_d.x   = den;
      f_d.y   = num;
      f_d.acc = '0;
    end
  end

  assign adv_f      = !f_valid_q || !cordic_in_stall;
  assign in_stall_o = !adv_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (adv_f) begin
      f_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_f && in_valid_i) begin
      f_q <= f_d;
    end
  end

  chs_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid_q),
    .in_data_i   (f_q),
    .in_stall_o  (cordic_in_stall),
    .out_valid_o (cordic_valid),
    .out_data_o  (cordic_out),
    .out_stall_i (!adv_p1)
  );

  logic                     p1_valid_q;
  logic [WRAP_W-2:0]        p1_v_q;
  logic                     p1_bad_q;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [WRAP_W-1:0] raw;
  logic signed [WRAP_W-1:0] v_d;

  assign acc_rnd = cordic_out.acc + ACC_HALF;
  assign raw     = cordic_out.zero ? '0 : WRAP_W'(acc_rnd >>> RAW_SHIFT);
  assign v_d     = raw - $signed({{(WRAP_W - HEAD_W){1'b0}}, heading_offset_q}) + TWO_CIRCLE_S;

  assign adv_p1 = !p1_valid_q || adv_p2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (adv_p1) begin
      p1_valid_q <= cordic_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_p1 && cordic_valid) begin
      p1_v_q   <= v_d[WRAP_W-2:0];
      p1_bad_q <= cordic_out.bad;
    end
  end

  logic              p2_valid_q;
  logic [HEAD_W-1:0] p2_h_q;
  logic              p2_bad_q;
  logic [WRAP_W-2:0] h_wide;

  always_comb begin
    priority if (p1_v_q >= TWO_CIRCLE_U) h_wide = p1_v_q - TWO_CIRCLE_U;
    else if (p1_v_q >= ONE_CIRCLE_U) h_wide = p1_v_q - ONE_CIRCLE_U;
    else h_wide = p1_v_q;
  end

  assign adv_p2 = !p2_valid_q || adv_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (adv_p2) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_p2 && p1_valid_q) begin
      p2_h_q   <= h_wide[HEAD_W-1:0];
      p2_bad_q <= p1_bad_q;
    end
  end

  logic              out_valid_q;
  logic [HEAD_W-1:0] heading_q;
  sector_e           sector_q;
  logic              bad_q;

  assign adv_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && p2_valid_q) begin
      heading_q <= p2_bad_q ? '0 : p2_h_q;
      sector_q  <= p2_bad_q ? SEC_N : sector_of(p2_h_q);
      bad_q     <= p2_bad_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign heading_o        = heading_q;
  assign compass_sector_o = sector_q;
  assign bad_axis_o       = bad_q;

endmodule

`default_nettype wire

/* rtl/chs_cordic.sv */
// Vectoring CORDIC pipeline with one register stage per rotation.
// Each stage holds its own valid bit and advances whenever the stage after it
// can take a transaction. Depends on chs_pkg.
`default_nettype none

module chs_cordic import chs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire cordic_t in_data_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  output cordic_t      out_data_o,
  input  wire logic    out_stall_i
);

  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] adv;
  cordic_t         data_q [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic    src_valid;
    cordic_t src;
    cordic_t rot_d;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    if (k == 0) begin : g_first
      assign src_valid = in_valid_i;
      assign src       = in_data_i;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src       = data_q[k-1];
    end

    if (k == NSTG - 1) begin : g_last
      assign adv[k] = !valid_q[k] || !out_stall_i;
    end else begin : g_mid
      assign adv[k] = !valid_q[k] || adv[k+1];
    end

    assign xs = src.x >>> k;
    assign ys = src.y >>> k;

    always_comb begin
      rot_d = src;
      if (!src.y[XY_W-1]) begin
        rot_d.x   = src.x + ys;
        rot_d.y   = src.y - xs;
        rot_d.acc = src.acc + ATAN_TAB[k];
      end else begin
        rot_d.x   = src.x - ys;
        rot_d.y   = src.y + xs;
        rot_d.acc = src.acc - ATAN_TAB[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv[k]) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && src_valid) begin
        data_q[k] <= rot_d;
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NSTG-1];
  assign out_data_o  = data_q[NSTG-1];

endmodule

`default_nettype wire
